@@ src/setb_pkg.sv @@
// ----------------------------------------------------------------------------
// Event timer bank package
// Shared types, action codes and sizes of the event timer bank.
// ----------------------------------------------------------------------------
package setb_pkg;

	localparam int TIMER_COUNT = 64;
	localparam int RANGE_LIMIT = 32;
	localparam int POS_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP = 3'd2;
	localparam logic [2:0] ACT_STOP_END = 3'd3;
	localparam logic [2:0] ACT_STOP_LIM = 3'd4;
	localparam logic [2:0] ACT_QUERY = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PRESCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_EVERY_TICK = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] timer_index;
		logic periodic;
		logic [31:0] period_count;
	} in_item_t;

	typedef struct packed {
		logic [63:0] expired_mask;
		logic any_expired;
		logic heartbeat_pulse;
		logic poll_pulse;
		logic [31:0] stopped_remaining;
		logic timer_enabled_flag;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic per;
		logic [31:0] rem;
		logic [31:0] rld;
	} entry_t;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] idx;
		logic periodic;
		logic [31:0] count;
		logic walk;
	} op_ctl_t;

	typedef struct packed {
		entry_t nxt;
		logic expire;
		logic stop_hit;
		logic query_hit;
	} alu_res_t;

endpackage

@@ src/soft_event_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// Event timer bank
// Bank of event timers held in a rotating ring of cells and advanced by ticks.
//
//   Channel  Signals                                    Direction  Beat
//   cmd      start, busy, cmd                           in         start & !busy
//   result   done, result                               out        done (one cycle)
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  in         cfg_valid & cfg_ready
//
// Every action rotates the whole ring once, one timer per cycle through the
// update unit, so the result strobe comes after the walk has passed every timer,
// and a new beat can be taken in the strobe cycle.
// Reset clears all timers, both prescalers and the registers to their defaults.
// The receiver cannot stall; busy is high only while the ring rotates.
// ----------------------------------------------------------------------------
module soft_event_timer_bank_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  setb_pkg::in_item_t cmd,
	output logic done,
	output setb_pkg::out_item_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [setb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [setb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int N = setb_pkg::TIMER_COUNT;
	localparam logic [setb_pkg::POS_W-1:0] POS_LAST = setb_pkg::POS_W'(N - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [setb_pkg::POS_W-1:0] pos_q;
	setb_pkg::op_ctl_t ctl_q;

	logic [7:0] tick_prescale_q;
	logic [7:0] heartbeat_period_q;
	logic poll_every_tick_q;
	logic [7:0] step_cnt_q;
	logic [7:0] hb_cnt_q;

	logic [63:0] mask_q;
	logic hb_q;
	logic poll_q;
	logic [31:0] stopped_q;
	logic flag_q;

	logic accept;
	logic walking;
	logic [7:0] step_inc;
	logic [7:0] hb_inc;
	logic step_fire;
	logic hb_fire;
	logic is_tick;

	setb_pkg::entry_t cell_d [N];
	setb_pkg::entry_t cell_o [N];
	setb_pkg::alu_res_t alu_res;

	assign accept = start && !busy;
	assign walking = (state_q == ST_WALK);
	assign busy = walking;
	assign done = (state_q == ST_DONE);
	assign cfg_ready = 1'b1;

	assign is_tick = (cmd.action == setb_pkg::ACT_TICK);
	assign step_inc = step_cnt_q + 8'd1;
	assign hb_inc = hb_cnt_q + 8'd1;
	assign step_fire = (step_inc >= tick_prescale_q);
	assign hb_fire = (hb_inc >= heartbeat_period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_prescale_q <= 8'd1;
			heartbeat_period_q <= 8'd6;
			poll_every_tick_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				setb_pkg::CFG_TICK_PRESCALE: tick_prescale_q <= cfg_data;
				setb_pkg::CFG_HEARTBEAT_PERIOD: heartbeat_period_q <= cfg_data;
				setb_pkg::CFG_POLL_EVERY_TICK: poll_every_tick_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			step_cnt_q <= 8'd0;
			hb_cnt_q <= 8'd0;
		end else begin
			case (state_q)
				ST_WALK: begin
					if (pos_q == POS_LAST) begin
						pos_q <= '0;
						state_q <= ST_DONE;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
					if (accept) begin
						state_q <= ST_WALK;
						pos_q <= '0;
						if (is_tick) begin
							step_cnt_q <= step_fire ? 8'd0 : step_inc;
							hb_cnt_q <= hb_fire ? 8'd0 : hb_inc;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.action <= cmd.action;
			ctl_q.idx <= cmd.timer_index;
			ctl_q.periodic <= cmd.periodic;
			ctl_q.count <= cmd.period_count;
			ctl_q.walk <= is_tick && step_fire;
			mask_q <= '0;
			hb_q <= is_tick && hb_fire;
			poll_q <= is_tick && poll_every_tick_q;
			stopped_q <= 32'd0;
			flag_q <= 1'b0;
		end else if (walking) begin
			if (alu_res.expire) begin
				mask_q[6'(pos_q)] <= 1'b1;
			end
			if (alu_res.stop_hit) begin
				stopped_q <= cell_o[0].rem;
			end
			if (alu_res.query_hit) begin
				flag_q <= cell_o[0].en;
			end
		end
	end

	setb_alu u_alu (
		.ctl (ctl_q),
		.pos (pos_q),
		.cur (cell_o[0]),
		.res (alu_res)
	);

	for (genvar i = 0; i < N; i++) begin : g_ring
		if (i == N - 1) begin : g_tail
			assign cell_d[i] = alu_res.nxt;
		end else begin : g_body
			assign cell_d[i] = cell_o[i+1];
		end
		setb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (walking),
			.d      (cell_d[i]),
			.q      (cell_o[i])
		);
	end

	always_comb begin
		result.expired_mask = mask_q;
		result.any_expired = |mask_q;
		result.heartbeat_pulse = hb_q;
		result.poll_pulse = poll_q;
		result.stopped_remaining = stopped_q;
		result.timer_enabled_flag = flag_q;
	end

	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_WALK))
		else $error("result strobe without a completed walk");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not start a walk");

	a_mask_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (mask_q != 64'd0)) |-> (ctl_q.action == setb_pkg::ACT_TICK))
		else $error("expiry mask set by an action other than tick");

	a_stopped_only_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (stopped_q != 32'd0)) |-> (ctl_q.action == setb_pkg::ACT_STOP))
		else $error("remaining count returned by an action other than stop");

endmodule

@@ src/setb_cell.sv @@
// ----------------------------------------------------------------------------
// Event timer bank cell
// One ring entry; each shift loads the next cell's or update unit's entry.
// ----------------------------------------------------------------------------
module setb_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  setb_pkg::entry_t d,
	output setb_pkg::entry_t q
);

	setb_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

@@ src/setb_alu.sv @@
// ----------------------------------------------------------------------------
// Event timer bank update unit
// Applies the current action to the timer entry at the head of the ring.
// ----------------------------------------------------------------------------
module setb_alu (
	input  setb_pkg::op_ctl_t ctl,
	input  logic [setb_pkg::POS_W-1:0] pos,
	input  setb_pkg::entry_t cur,
	output setb_pkg::alu_res_t res
);

	localparam logic [6:0] LIMIT7 = 7'(setb_pkg::RANGE_LIMIT);

	logic [6:0] pos7;
	logic [6:0] idx7;
	logic hit;
	logic from_idx;
	logic below_lim;
	logic [31:0] dec;

	assign pos7 = 7'(pos);
	assign idx7 = {1'b0, ctl.idx};
	assign hit = (pos7 == idx7);
	assign from_idx = (pos7 >= idx7);
	assign below_lim = (pos7 < LIMIT7);
	assign dec = cur.rem - 32'd1;

	always_comb begin
		res = '0;
		res.nxt = cur;
		case (ctl.action)
			setb_pkg::ACT_TICK: begin
				if (ctl.walk && cur.en && (cur.rem != 32'd0)) begin
					res.nxt.rem = dec;
					if (dec == 32'd0) begin
						res.expire = 1'b1;
						if (cur.per) begin
							res.nxt.rem = cur.rld;
						end else begin
							res.nxt.en = 1'b0;
						end
					end
				end
			end
			setb_pkg::ACT_START: begin
				if (hit) begin
					res.nxt.en = 1'b1;
					res.nxt.per = ctl.periodic;
					res.nxt.rem = ctl.count;
					res.nxt.rld = ctl.count;
				end
			end
			setb_pkg::ACT_STOP: begin
				if (hit) begin
					res.stop_hit = 1'b1;
					res.nxt.en = 1'b0;
					res.nxt.rem = 32'd0;
				end
			end
			setb_pkg::ACT_STOP_END: begin
				if (from_idx) begin
					res.nxt.en = 1'b0;
					res.nxt.rem = 32'd0;
				end
			end
			setb_pkg::ACT_STOP_LIM: begin
				if (from_idx && below_lim) begin
					res.nxt.en = 1'b0;
					res.nxt.rem = 32'd0;
				end
			end
			setb_pkg::ACT_QUERY: begin
				if (hit) begin
					res.query_hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ bench/setb_checker.sv @@
// ----------------------------------------------------------------------------
// Event timer bank checker
// Watches the command, result and register channels of the timer bank. It
// keeps its own copy of every timer, both prescalers and the registers,
// works out the result of each accepted command, and compares each result
// strobe with the oldest result still due, field by field.
// ----------------------------------------------------------------------------
module setb_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  setb_pkg::in_item_t cmd,
	input  logic done,
	input  setb_pkg::out_item_t result,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [setb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [setb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int outstanding
);

	logic t_en [setb_pkg::TIMER_COUNT];
	logic t_per [setb_pkg::TIMER_COUNT];
	logic [31:0] t_rem [setb_pkg::TIMER_COUNT];
	logic [31:0] t_rld [setb_pkg::TIMER_COUNT];
	logic [7:0] step_count;
	logic [7:0] hb_count;
	logic [7:0] step_period;
	logic [7:0] hb_period;
	logic poll_mode;

	setb_pkg::out_item_t due_results [$];
	setb_pkg::out_item_t want;

	function automatic setb_pkg::out_item_t advance_bank(setb_pkg::in_item_t c);
		setb_pkg::out_item_t r;
		int last;
		r = '0;
		case (c.action)
			setb_pkg::ACT_TICK: begin
				r.poll_pulse = poll_mode;
				hb_count = hb_count + 8'd1;
				if (hb_count >= hb_period) begin
					hb_count = '0;
					r.heartbeat_pulse = 1'b1;
				end
				step_count = step_count + 8'd1;
				if (step_count >= step_period) begin
					step_count = '0;
					for (int i = 0; i < setb_pkg::TIMER_COUNT; i++) begin
						if (t_en[i] && t_rem[i] != 32'd0) begin
							t_rem[i] = t_rem[i] - 32'd1;
							if (t_rem[i] == 32'd0) begin
								r.expired_mask[i] = 1'b1;
								if (t_per[i])
									t_rem[i] = t_rld[i];
								else
									t_en[i] = 1'b0;
							end
						end
					end
				end
			end
			setb_pkg::ACT_START: begin
				if (int'(c.timer_index) < setb_pkg::TIMER_COUNT) begin
					t_per[c.timer_index] = c.periodic;
					t_rem[c.timer_index] = c.period_count;
					t_rld[c.timer_index] = c.period_count;
					t_en[c.timer_index] = 1'b1;
				end
			end
			setb_pkg::ACT_STOP: begin
				if (int'(c.timer_index) < setb_pkg::TIMER_COUNT) begin
					t_en[c.timer_index] = 1'b0;
					r.stopped_remaining = t_rem[c.timer_index];
					t_rem[c.timer_index] = '0;
				end
			end
			setb_pkg::ACT_STOP_END, setb_pkg::ACT_STOP_LIM: begin
				last = (c.action == setb_pkg::ACT_STOP_END) ? setb_pkg::TIMER_COUNT :
					setb_pkg::RANGE_LIMIT;
				if (last > setb_pkg::TIMER_COUNT)
					last = setb_pkg::TIMER_COUNT;
				for (int i = int'(c.timer_index); i < last; i++) begin
					t_en[i] = 1'b0;
					t_rem[i] = '0;
				end
			end
			setb_pkg::ACT_QUERY: begin
				if (int'(c.timer_index) < setb_pkg::TIMER_COUNT)
					r.timer_enabled_flag = t_en[c.timer_index];
			end
			default: begin
			end
		endcase
		r.any_expired = |r.expired_mask;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < setb_pkg::TIMER_COUNT; i++) begin
				t_en[i] = 1'b0;
				t_per[i] = 1'b0;
				t_rem[i] = '0;
				t_rld[i] = '0;
			end
			step_count = '0;
			hb_count = '0;
			step_period = 8'd1;
			hb_period = 8'd6;
			poll_mode = 1'b0;
			due_results.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result strobe with no result due, got %0h", $time, result);
				end else begin
					want = due_results.pop_front();
					check_field("expired_mask", want.expired_mask, result.expired_mask);
					check_field("any_expired", 64'(want.any_expired),
						64'(result.any_expired));
					check_field("heartbeat_pulse", 64'(want.heartbeat_pulse),
						64'(result.heartbeat_pulse));
					check_field("poll_pulse", 64'(want.poll_pulse),
						64'(result.poll_pulse));
					check_field("stopped_remaining", 64'(want.stopped_remaining),
						64'(result.stopped_remaining));
					check_field("timer_enabled_flag", 64'(want.timer_enabled_flag),
						64'(result.timer_enabled_flag));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					setb_pkg::CFG_TICK_PRESCALE: step_period = cfg_data;
					setb_pkg::CFG_HEARTBEAT_PERIOD: hb_period = cfg_data;
					setb_pkg::CFG_POLL_EVERY_TICK: poll_mode = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (start && !busy)
				due_results.push_back(advance_bank(cmd));
			outstanding = due_results.size();
		end
	end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Event timer bank testbench
// Drives the timer bank with a short directed sequence and then with random
// commands under several register settings, with random gaps on the command
// side. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam logic [setb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	setb_pkg::in_item_t cmd;
	logic done;
	setb_pkg::out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [setb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [setb_pkg::CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int outstanding;
	int cycles = 0;
	bit calm;
	logic [7:0] presc_set [6] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd0, 8'd4};
	logic [7:0] hb_set [6] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd0, 8'd17};
	bit poll_set [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

	soft_event_timer_bank_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	setb_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic setb_pkg::in_item_t make_cmd(logic [2:0] a, int unsigned i, bit p,
			logic [31:0] n);
		setb_pkg::in_item_t c;
		c.action = a;
		c.timer_index = i[5:0];
		c.periodic = p;
		c.period_count = n;
		return c;
	endfunction

	function automatic setb_pkg::in_item_t rand_item();
		setb_pkg::in_item_t c;
		int unsigned r;
		c.timer_index = 6'($urandom_range(0, 63));
		c.periodic = 1'($urandom_range(0, 1));
		c.period_count = $urandom;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			c.action = setb_pkg::ACT_TICK;
		end else if (r < 70) begin
			c.action = setb_pkg::ACT_START;
			r = $urandom_range(0, 9);
			if (r < 7)
				c.period_count = $urandom_range(0, 6);
			else if (r < 9)
				c.period_count = $urandom_range(7, 40);
		end else if (r < 80) begin
			c.action = setb_pkg::ACT_STOP;
		end else if (r < 84) begin
			c.action = setb_pkg::ACT_STOP_END;
		end else if (r < 88) begin
			c.action = setb_pkg::ACT_STOP_LIM;
		end else if (r < 96) begin
			c.action = setb_pkg::ACT_QUERY;
		end else begin
			c.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
		end
		return c;
	endfunction

	task automatic issue(input setb_pkg::in_item_t c);
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		wait (outstanding == 0);
	endtask

	task automatic write_reg(input logic [setb_pkg::CFG_IDX_W-1:0] idx,
			input logic [setb_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		logic [7:0] presc;
		logic [7:0] hb;
		logic [7:0] poll_data;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: one decrement step per tick, heartbeat every sixth tick.
		issue(make_cmd(setb_pkg::ACT_QUERY, 0, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_START, 0, 1'b0, 32'd1));
		issue(make_cmd(setb_pkg::ACT_START, 63, 1'b1, 32'd2));
		issue(make_cmd(setb_pkg::ACT_START, 5, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_START, 40, 1'b0, 32'hFFFF_FFFF));
		issue(make_cmd(setb_pkg::ACT_TICK, 0, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_TICK, 63, 1'b1, 32'hFFFF_FFFF));
		issue(make_cmd(setb_pkg::ACT_QUERY, 0, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_QUERY, 5, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_STOP, 40, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_STOP, 63, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_START, 31, 1'b1, 32'd3));
		issue(make_cmd(setb_pkg::ACT_START, 32, 1'b0, 32'd3));
		issue(make_cmd(setb_pkg::ACT_STOP_LIM, 30, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_QUERY, 31, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_QUERY, 32, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_STOP_END, 32, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_STOP_LIM, 40, 1'b0, 32'd0));
		issue(make_cmd(ACT_SPARE_6, $urandom_range(0, 63), 1'b1, $urandom));
		issue(make_cmd(ACT_SPARE_7, $urandom_range(0, 63), 1'b0, $urandom));
		repeat (4) issue(make_cmd(setb_pkg::ACT_TICK, 0, 1'b0, 32'd0));
		issue(make_cmd(setb_pkg::ACT_STOP, 0, 1'b0, 32'd0));

		for (int p = 0; p < 6; p++) begin
			drain();
			presc = presc_set[p];
			hb = hb_set[p];
			poll_data = 8'($urandom);
			poll_data[0] = poll_set[p];
			if (p == 4) begin
				presc = 8'($urandom_range(0, 8));
				hb = 8'($urandom_range(0, 255));
			end
			write_reg(setb_pkg::CFG_TICK_PRESCALE, presc);
			write_reg(setb_pkg::CFG_HEARTBEAT_PERIOD, hb);
			write_reg(setb_pkg::CFG_POLL_EVERY_TICK, poll_data);
			if (p == 2)
				write_reg(CFG_SPARE, 8'($urandom));
			@(negedge clk);
			cfg_valid = 1'b0;
			calm = (p == 2);
			n = (p == 1) ? 150 : 330;
			repeat (n) begin
				issue(rand_item());
				if (!calm && $urandom_range(0, 99) < 2) begin
					drain();
				end else if (!calm && $urandom_range(0, 99) < 36) begin
					@(negedge clk);
					start = 1'b0;
					cmd = rand_item();
					repeat ($urandom_range(0, 69)) @(negedge clk);
				end
			end
		end

		drain();
		repeat (setb_pkg::TIMER_COUNT + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
